// ----- hw/rtl/imu_sei_pkg.sv -----
// Shared constants, types and fixed-point helpers for the strapdown integrator.
package imu_sei_pkg;

  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_POS_X = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_POS_Y = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_POS_Z = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_VEL_X = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_VEL_Y = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_VEL_Z = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_ATT   = 4'd7;

  localparam logic [23:0] TIME_STEP_RST = 24'd83886;
  localparam logic [63:0] INIT_ATT_RST  = 64'h4000_0000_0000_0000;

  localparam logic signed [63:0] GRAV_Q14 = 64'sd160727;
  localparam logic signed [32:0] ONE_Q30  = 33'sd1073741824;

  typedef struct packed {
    logic first;
    logic neg;
    logic shl16;
  } mac_op_t;

  function automatic logic signed [63:0] rnd64(input logic signed [63:0] v,
                                               input logic [5:0] s);
    logic signed [63:0] half;
    half = 64'sd1 <<< (s - 6'd1);
    return (v + half) >>> s;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fff_ffff;
    else if (v < -64'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ----- hw/rtl/imu_strapdown_euler_integrator.sv -----
// Top level: strapdown attitude, velocity and position integrator, one shared MAC.
// Flow: the arming word loads the initial state and gives no result; every later
//   word gives a result once the output is free; new words stall until idle.
// Pace: each word's work is set by the single shared multiplier
//   (50 products), the 32-step square root and four 31-step divisions; a stalled
//   result word holds the sequencer until the output register is free.
// Reset: synchronous; registers return to their reset values, state is loaded
//   from them and the block waits for an arming word.
module imu_strapdown_euler_integrator (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [31:0]         stamp,
  input  logic signed [23:0]  rate_x,
  input  logic signed [23:0]  rate_y,
  input  logic signed [23:0]  rate_z,
  input  logic signed [23:0]  force_x,
  input  logic signed [23:0]  force_y,
  input  logic signed [23:0]  force_z,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         out_stamp,
  output logic signed [31:0]  att_w,
  output logic signed [31:0]  att_x,
  output logic signed [31:0]  att_y,
  output logic signed [31:0]  att_z,
  output logic signed [31:0]  pos_x,
  output logic signed [31:0]  pos_y,
  output logic signed [31:0]  pos_z,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [imu_sei_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]         cfg_data
);
  import imu_sei_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ISSUE, S_DRAIN, S_WB, S_SCALE, S_SQRT, S_DIVI, S_DIV, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    P_H, P_SS, P_T, P_AW, P_AX, P_N, P_AD, P_PV, P_PD
  } phase_t;

  state_t state;
  phase_t phase;

  logic [23:0]        time_step;
  logic [31:0]        init_pos [3];
  logic [31:0]        init_vel [3];
  logic [63:0]        init_att;

  logic signed [31:0] att [4];
  logic signed [31:0] pos [3];
  logic signed [31:0] vel [3];
  logic signed [31:0] nq [4];
  logic signed [31:0] acc_a [3];
  logic               armed;

  logic [31:0]        stamp_r;
  logic signed [23:0] gyr [3];
  logic signed [23:0] frc [3];

  logic signed [36:0] c [3];
  logic [2:0]         k;
  logic signed [32:0] cs [4];
  logic [63:0]        sx;
  logic [63:0]        sr;
  logic [63:0]        sb;
  logic [31:0]        rem;
  logic [30:0]        quo;
  logic [4:0]         bitc;
  logic [1:0]         di;
  logic signed [32:0] dq [4];
  logic signed [32:0] t [3];
  logic signed [32:0] aw [3];
  logic signed [40:0] ad [3];
  logic signed [33:0] pvv [3];

  logic [1:0]         ax;
  logic [1:0]         term;

  logic               in_acc;
  logic               mac_issue;
  mac_op_t            mop;
  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic signed [63:0] macc;
  logic signed [32:0] dt33;
  logic [1:0]         ia;
  logic [1:0]         ib;
  logic [1:0]         last_term;
  logic               last_ax;
  logic [3:0]         nneg;

  logic signed [63:0] r11, r16, r24, r27, r30, r31;
  logic signed [36:0] hv;
  logic [36:0]        hmag;
  logic [2:0]         kn;
  logic signed [63:0] axs;
  logic signed [63:0] psum;
  logic signed [63:0] vsum;
  logic [63:0]        rb;
  logic               sq_ge;
  logic [31:0]        cmag;
  logic [32:0]        rem2;
  logic               dv_ge;
  logic [32:0]        rem2n;
  logic [30:0]        qn;
  logic signed [32:0] qnx;

  imu_sei_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .issue (mac_issue),
    .op    (mop),
    .a     (ma),
    .b     (mb),
    .acc   (macc)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign mac_issue = (state == S_ISSUE);
  assign dt33      = {9'd0, time_step};

  always_comb begin
    case (ax)
      2'd0: begin ia = 2'd1; ib = 2'd2; end
      2'd1: begin ia = 2'd2; ib = 2'd0; end
      2'd2: begin ia = 2'd0; ib = 2'd1; end
      default: begin ia = 2'd0; ib = 2'd0; end
    endcase
    case (ax)
      2'd0: nneg = 4'b1110;
      2'd1: nneg = 4'b1000;
      2'd2: nneg = 4'b0010;
      default: nneg = 4'b0100;
    endcase
    case (phase)
      P_SS, P_N: last_term = 2'd3;
      P_T, P_AX, P_PD: last_term = 2'd1;
      default: last_term = 2'd0;
    endcase
    case (phase)
      P_SS: last_ax = 1'b1;
      P_N: last_ax = (ax == 2'd3);
      default: last_ax = (ax == 2'd2);
    endcase
  end

  always_comb begin
    mop       = '0;
    mop.first = (term == 2'd0);
    ma        = '0;
    mb        = '0;
    case (phase)
      P_H: begin
        ma = 33'(gyr[ax]);
        mb = dt33;
      end
      P_SS: begin
        ma = cs[term];
        mb = cs[term];
      end
      P_T: begin
        if (term == 2'd0) begin
          ma = 33'(att[2'(ia + 2'd1)]);
          mb = 33'(frc[ib]);
        end else begin
          ma = 33'(att[2'(ib + 2'd1)]);
          mb = 33'(frc[ia]);
          mop.neg = 1'b1;
        end
      end
      P_AW: begin
        ma = 33'(att[0]);
        mb = t[ax];
      end
      P_AX: begin
        if (term == 2'd0) begin
          ma = 33'(att[2'(ia + 2'd1)]);
          mb = t[ib];
        end else begin
          ma = 33'(att[2'(ib + 2'd1)]);
          mb = t[ia];
          mop.neg = 1'b1;
        end
      end
      P_N: begin
        ma = 33'(att[term]);
        mb = dq[term ^ ax];
        mop.neg = nneg[term];
      end
      P_AD: begin
        ma = 33'(acc_a[ax]);
        mb = dt33;
      end
      P_PV: begin
        ma = 33'(vel[ax]);
        mb = dt33;
      end
      P_PD: begin
        mb = dt33;
        if (term == 2'd0) begin
          ma = 33'(ad[ax] >>> 16);
          mop.shl16 = 1'b1;
        end else begin
          ma = {17'd0, ad[ax][15:0]};
        end
      end
      default: begin
        ma = '0;
      end
    endcase
  end

  always_comb begin
    r11  = rnd64(macc, 6'd11);
    r16  = rnd64(macc, 6'd16);
    r24  = rnd64(macc, 6'd24);
    r27  = rnd64(macc, 6'd27);
    r30  = rnd64(macc, 6'd30);
    r31  = rnd64(macc, 6'd31);
    hv   = r11[36:0];
    hmag = hv[36] ? 37'(-hv) : 37'(hv);
    if (hmag[36]) kn = 3'd6;
    else if (hmag[35]) kn = 3'd5;
    else if (hmag[34]) kn = 3'd4;
    else if (hmag[33]) kn = 3'd3;
    else if (hmag[32]) kn = 3'd2;
    else if (hmag[31]) kn = 3'd1;
    else kn = 3'd0;
    axs  = {{38{frc[ax][23]}}, frc[ax], 2'b00} + 64'(aw[ax]) + r30
         - ((ax == 2'd2) ? GRAV_Q14 : 64'sd0);
    psum = 64'(pos[ax]) + 64'(pvv[ax]) + r31;
    vsum = 64'(vel[ax]) + rnd64(64'(ad[ax]), 6'd6);
    rb    = sr + sb;
    sq_ge = (sx >= rb);
    cmag  = cs[di][32] ? 32'(-cs[di]) : 32'(cs[di]);
    rem2  = {rem, (bitc == 5'd30) ? cmag[0] : 1'b0};
    dv_ge = (rem2 >= {1'b0, sr[31:0]});
    rem2n = dv_ge ? rem2 - {1'b0, sr[31:0]} : rem2;
    qn    = {quo[29:0], dv_ge};
    qnx   = {2'b00, qn};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= TIME_STEP_RST;
      init_att  <= INIT_ATT_RST;
      for (int i = 0; i < 3; i++) begin
        init_pos[i] <= '0;
        init_vel[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TIME_STEP:  time_step   <= cfg_data[23:0];
        REG_INIT_POS_X: init_pos[0] <= cfg_data[31:0];
        REG_INIT_POS_Y: init_pos[1] <= cfg_data[31:0];
        REG_INIT_POS_Z: init_pos[2] <= cfg_data[31:0];
        REG_INIT_VEL_X: init_vel[0] <= cfg_data[31:0];
        REG_INIT_VEL_Y: init_vel[1] <= cfg_data[31:0];
        REG_INIT_VEL_Z: init_vel[2] <= cfg_data[31:0];
        REG_INIT_ATT:   init_att    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= P_H;
      armed     <= 1'b0;
      out_valid <= 1'b0;
      ax        <= '0;
      term      <= '0;
      att[0]    <= {INIT_ATT_RST[63:48], 16'd0};
      att[1]    <= {INIT_ATT_RST[47:32], 16'd0};
      att[2]    <= {INIT_ATT_RST[31:16], 16'd0};
      att[3]    <= {INIT_ATT_RST[15:0], 16'd0};
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0;
        vel[i] <= '0;
      end
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (!armed) begin
              armed  <= 1'b1;
              att[0] <= {init_att[63:48], 16'd0};
              att[1] <= {init_att[47:32], 16'd0};
              att[2] <= {init_att[31:16], 16'd0};
              att[3] <= {init_att[15:0], 16'd0};
              for (int i = 0; i < 3; i++) begin
                pos[i] <= init_pos[i];
                vel[i] <= init_vel[i];
              end
            end else begin
              stamp_r <= stamp;
              gyr[0]  <= rate_x;
              gyr[1]  <= rate_y;
              gyr[2]  <= rate_z;
              frc[0]  <= force_x;
              frc[1]  <= force_y;
              frc[2]  <= force_z;
              k       <= '0;
              phase   <= P_H;
              ax      <= '0;
              term    <= '0;
              state   <= S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          if (term == last_term) begin
            state <= S_DRAIN;
          end else begin
            term <= term + 2'd1;
          end
        end
        S_DRAIN: begin
          state <= S_WB;
        end
        S_WB: begin
          case (phase)
            P_H: begin
              c[ax] <= hv;
              if (kn > k) k <= kn;
            end
            P_SS: begin
              sx <= macc;
              sr <= '0;
              sb <= 64'h4000_0000_0000_0000;
            end
            P_T:  t[ax]     <= r27[32:0];
            P_AW: aw[ax]    <= r30[32:0];
            P_AX: acc_a[ax] <= sat32(axs);
            P_N:  nq[ax]    <= sat32(r30);
            P_AD: ad[ax]    <= r16[40:0];
            P_PV: pvv[ax]   <= r24[33:0];
            P_PD: begin
              pos[ax] <= sat32(psum);
              vel[ax] <= sat32(vsum);
            end
            default: ;
          endcase
          term <= '0;
          if (!last_ax) begin
            ax    <= ax + 2'd1;
            state <= S_ISSUE;
          end else begin
            ax <= '0;
            case (phase)
              P_H:  state <= S_SCALE;
              P_SS: state <= S_SQRT;
              P_T: begin
                phase <= P_AW;
                state <= S_ISSUE;
              end
              P_AW: begin
                phase <= P_AX;
                state <= S_ISSUE;
              end
              P_AX: begin
                phase <= P_N;
                state <= S_ISSUE;
              end
              P_N: begin
                phase <= P_AD;
                state <= S_ISSUE;
              end
              P_AD: begin
                phase <= P_PV;
                state <= S_ISSUE;
              end
              P_PV: begin
                phase <= P_PD;
                state <= S_ISSUE;
              end
              P_PD: begin
                for (int i = 0; i < 4; i++) att[i] <= nq[i];
                state <= S_DONE;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SCALE: begin
          cs[0] <= ONE_Q30 >>> k;
          for (int i = 0; i < 3; i++) cs[i+1] <= 33'(c[i] >>> k);
          phase <= P_SS;
          ax    <= '0;
          term  <= '0;
          state <= S_ISSUE;
        end
        S_SQRT: begin
          if (sq_ge) begin
            sx <= sx - rb;
            sr <= (sr >> 1) + sb;
          end else begin
            sr <= sr >> 1;
          end
          sb <= sb >> 2;
          if (sb[0]) begin
            di    <= '0;
            state <= S_DIVI;
          end
        end
        S_DIVI: begin
          rem   <= cmag >> 1;
          bitc  <= 5'd30;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= rem2n[31:0];
          quo <= qn;
          if (bitc == 5'd0) begin
            dq[di] <= cs[di][32] ? -qnx : qnx;
            if (di == 2'd3) begin
              phase <= P_T;
              ax    <= '0;
              term  <= '0;
              state <= S_ISSUE;
            end else begin
              di    <= di + 2'd1;
              state <= S_DIVI;
            end
          end else begin
            bitc <= bitc - 5'd1;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_stamp <= stamp_r;
            att_w     <= att[0];
            att_x     <= att[1];
            att_y     <= att[2];
            att_z     <= att[3];
            pos_x     <= pos[0];
            pos_y     <= pos[1];
            pos_z     <= pos[2];
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_root_fits: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> sr[63:32] == 32'd0)
    else $error("square root exceeds 32 bits");

  a_rem_below_root: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> {32'd0, rem} < sr)
    else $error("division remainder not below divisor");

  a_unarmed_idle: assert property (@(posedge clk) disable iff (rst)
    !armed |-> state == S_IDLE)
    else $error("sequencer active before arming");

  a_out_taken: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && state != S_DONE |=> !out_valid)
    else $error("result word repeated");

endmodule

// ----- hw/rtl/imu_sei_mac.sv -----
// Shared signed multiply-accumulate unit with a registered product.
module imu_sei_mac (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 issue,
  input  imu_sei_pkg::mac_op_t op,
  input  logic signed [32:0]   a,
  input  logic signed [32:0]   b,
  output logic signed [63:0]   acc
);
  import imu_sei_pkg::*;

  logic signed [65:0] prod;
  logic               pvld;
  mac_op_t            pop;
  logic signed [63:0] base;
  logic signed [63:0] addend;

  always_comb begin
    base   = pop.first ? 64'sd0 : acc;
    addend = pop.shl16 ? {prod[47:0], 16'd0} : prod[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pvld <= 1'b0;
    end else begin
      pvld <= issue;
    end
    prod <= a * b;
    pop  <= op;
    if (pvld) begin
      acc <= pop.neg ? base - addend : base + addend;
    end
  end

endmodule
